### sv/mcmr_pkg.sv
// Shared types, codes and default sizes for the multi-channel message ring.
package mcmr_pkg;

  // Default sizes handed to the top level's parameters.
  localparam int DEF_CHANNELS   = 4;
  localparam int DEF_MAX_SLOTS  = 16;
  localparam int DEF_SLOT_BYTES = 8;

  // Depths of the command queue and the result queue.
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 4;

  // Reset values of the configuration registers.
  localparam logic [4:0] SLOTS_RST = 5'd16;
  localparam logic [3:0] MSGB_RST  = 4'd8;

  // Operation codes of a request.
  typedef enum logic {
    OP_SEND = 1'b0,
    OP_RECV = 1'b1
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_SLOTS = 1'b0,
    CFG_MSGB  = 1'b1
  } cfg_idx_t;

  // A classified request waiting in the command queue.
  typedef struct packed {
    op_t         op;
    logic [3:0]  channel;
    logic [3:0]  length;
    logic [63:0] payload;
    logic        bad;
  } cmd_t;

  // A finished result waiting in the result queue.
  typedef struct packed {
    status_t     status;
    logic [3:0]  count;
    logic [63:0] message;
    logic [31:0] idle_polls;
  } res_t;

endpackage

### sv/mcmr_fifo.sv
// Small first-in first-out queue built from registers, used for commands and results.
module mcmr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH):0]     level
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int LVW  = PTRW + 1;

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [LVW-1:0]   level_r, level_nxt;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill level bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = store_r[rd_ptr_r];
  assign empty = (level_r == '0);
  assign full  = (level_r == LVW'(DEPTH));
  assign level = level_r;

endmodule

### sv/mcmr_front.sv
// Front end: checks and classifies incoming requests and queues them for execution.
module mcmr_front
  import mcmr_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [3:0]  in_channel,
  input  logic [3:0]  in_length,
  input  logic [63:0] in_payload,
  input  logic [3:0]  msgb_cfg,
  input  logic        clearing,
  input  logic        cmd_pop,
  output cmd_t        cmd,
  output logic        cmd_empty
);

  cmd_t                     cmd_in;
  logic [3:0]               eff_bytes;
  logic                     chan_ok;
  logic                     len_ok;
  logic                     q_full;
  logic [$clog2(CMDQ_DEPTH):0] q_level;

  // Effective message size is capped at the slot width.
  assign eff_bytes = (msgb_cfg > 4'(SLOT_BYTES)) ? 4'(SLOT_BYTES) : msgb_cfg;

  // Parameter checks; a bad request still travels so its result keeps order.
  always_comb begin
    chan_ok        = ({1'b0, in_channel} < 5'(CHANNELS));
    len_ok         = (in_length != 4'd0) && (in_length <= eff_bytes);
    cmd_in.op      = op_t'(in_op);
    cmd_in.channel = in_channel;
    cmd_in.length  = in_length;
    cmd_in.payload = in_payload;
    cmd_in.bad     = !chan_ok || ((op_t'(in_op) == OP_SEND) && !len_ok);
  end

  // No request is taken while the slot store is being cleared.
  assign in_full = q_full || clearing;

  mcmr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty),
    .full  (q_full),
    .level (q_level)
  );

  // The level is not needed here beyond the full flag.
  logic unused_level;
  assign unused_level = ^q_level;

endmodule

### sv/mcmr_back.sv
// Back end: per-channel pointers, slot store, idle poll counter and the result stage.
module mcmr_back
  import mcmr_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [4:0]                  slots_cfg,
  input  logic [3:0]                  msgb_cfg,
  input  cmd_t                        cmd,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  input  logic [$clog2(RESQ_DEPTH):0] res_level,
  output logic                        res_push,
  output res_t                        res_data,
  output logic                        clearing
);

  localparam int PW    = $clog2(MAX_SLOTS);
  localparam int SW    = (PW + 1 > 5) ? PW + 1 : 5;
  localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * MAX_SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = SLOT_BYTES * 8;

  // Next pointer with wrap at the effective ring size.
  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p,
                                              input logic [SW-1:0] lim);
    logic [SW-1:0] n;
    n = SW'(p) + SW'(1);
    next_slot = (n >= lim) ? '0 : n[PW-1:0];
  endfunction

  function automatic logic [DW-1:0] in_payload_bits(input logic [63:0] p);
    in_payload_bits = p[DW-1:0];
  endfunction

  logic [PW-1:0]   write_slot_r [CHANNELS];
  logic [PW-1:0]   read_slot_r  [CHANNELS];
  logic [DW-1:0]   slot_mem     [DEPTH];
  logic [DW-1:0]   mem_q_r;
  logic [31:0]     idle_r, idle_nxt;
  logic            clr_r, clr_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;

  logic            res_v_r;
  status_t         res_status_r;
  logic [3:0]      res_count_r;
  logic [31:0]     res_idle_r;
  logic            res_rd_r;

  logic [SW-1:0]   eff_slots;
  logic [3:0]      eff_bytes;
  logic            issue;
  logic [CIW-1:0]  ch;
  logic [PW-1:0]   wp, rp, ns, nr;
  logic [AW-1:0]   base;
  status_t         st;
  logic [3:0]      cnt;
  logic            send_wr, recv_rd;
  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [DW-1:0]   mem_wd;
  logic [SLOT_BYTES-1:0] mem_be;

  // Effective configuration.
  assign eff_slots = (SW'(slots_cfg) > SW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(slots_cfg);
  assign eff_bytes = (msgb_cfg > 4'(SLOT_BYTES)) ? 4'(SLOT_BYTES) : msgb_cfg;

  // A request is executed only when its result is sure of a place in the result queue.
  assign issue   = !cmd_empty && !clr_r &&
                   ((SW'(res_level) + SW'(res_v_r)) < SW'(RESQ_DEPTH));
  assign cmd_pop = issue;

  // Pointer look-up for the request's channel.
  always_comb begin
    ch   = cmd.channel[CIW-1:0];
    wp   = write_slot_r[ch];
    rp   = read_slot_r[ch];
    ns   = next_slot(wp, eff_slots);
    nr   = next_slot(rp, eff_slots);
    base = AW'(ch) * AW'(MAX_SLOTS);
  end

  // Execution of one request: status, count and idle counter update.
  always_comb begin
    st       = ST_BAD;
    cnt      = 4'd0;
    send_wr  = 1'b0;
    recv_rd  = 1'b0;
    idle_nxt = idle_r;
    if (issue && !cmd.bad) begin
      if (cmd.op == OP_SEND) begin
        if (ns == rp) begin
          st = ST_FULL;
        end else begin
          send_wr = 1'b1;
          st      = ST_DONE;
          cnt     = cmd.length;
        end
      end else begin
        if (rp == wp) begin
          idle_nxt = idle_r + 32'd1;
          st       = ST_EMPTY;
        end else begin
          recv_rd  = 1'b1;
          idle_nxt = '0;
          st       = ST_DONE;
          cnt      = eff_bytes;
        end
      end
    end
  end

  // Clearing pass after reset walks the store one slot a cycle.
  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  assign clearing = clr_r;

  // Store write port: zeroes during the clearing pass, else the low bytes of a send.
  always_comb begin
    mem_we = clr_r || send_wr;
    mem_wa = clr_r ? clr_addr_r : base + AW'(ns);
    mem_wd = clr_r ? '0 : in_payload_bits(cmd.payload);
    mem_ra = base + AW'(nr);
    for (int b = 0; b < SLOT_BYTES; b++) begin
      mem_be[b] = clr_r || (4'(b) < cmd.length);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        write_slot_r[c] <= '0;
        read_slot_r[c]  <= '0;
      end
      idle_r     <= '0;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      res_v_r    <= 1'b0;
    end else begin
      if (send_wr) begin
        write_slot_r[ch] <= ns;
      end
      if (recv_rd) begin
        read_slot_r[ch] <= nr;
      end
      idle_r     <= idle_nxt;
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
      res_v_r    <= issue;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk) begin
    if (issue) begin
      res_status_r <= st;
      res_count_r  <= cnt;
      res_idle_r   <= idle_nxt;
      res_rd_r     <= recv_rd;
    end
  end

  // Slot store with byte lane writes and a registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int b = 0; b < SLOT_BYTES; b++) begin
        if (mem_be[b]) begin
          slot_mem[mem_wa][b*8 +: 8] <= mem_wd[b*8 +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (recv_rd) begin
      mem_q_r <= slot_mem[mem_ra];
    end
  end

  // Finished result heads for the result queue.
  always_comb begin
    res_push            = res_v_r;
    res_data.status     = res_status_r;
    res_data.count      = res_count_r;
    res_data.message    = res_rd_r ? 64'(mem_q_r) : '0;
    res_data.idle_polls = res_idle_r;
  end

endmodule

### sv/multi_channel_message_ring_unit.sv
// Top level of the multi-channel message ring: configuration registers and the three parts.
//
// One direction of a message link as CHANNELS circular queues of MAX_SLOTS slots, each
// slot SLOT_BYTES wide. Requests go in on the in_ side like a queue push and one result per
// request comes out on the out_ side like a queue pop, in request order. A send writes the
// low length bytes of the next slot and is refused as full when that slot is the read
// pointer, so one slot always stays empty; a receive returns the slot word and the
// configured message size, or reports empty and counts the idle poll. The block sustains
// one request per cycle while the result queue has room and no clearing pass runs; a
// request's result passes the command queue, then execution against the channel pointers
// and slot store together with the registered store read, then the result stage and the
// result queue. After reset the slot store is zeroed by a pass over all CHANNELS*MAX_SLOTS
// slots, during which in_full stays high; configuration writes are taken at any time
// (cfg_ready is always high) but are meant for when no request is in flight.
module multi_channel_message_ring_unit
  import mcmr_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_op,
  input  logic [3:0]  in_channel,
  input  logic [3:0]  in_length,
  input  logic [63:0] in_payload,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [3:0]  out_count,
  output logic [63:0] out_message,
  output logic [31:0] out_idle_polls,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  logic [4:0]  slots_r, slots_nxt;
  logic [3:0]  msgb_r, msgb_nxt;
  cmd_t        cmd;
  logic        cmd_empty;
  logic        cmd_pop;
  logic        clearing;
  logic        res_push;
  res_t        res_in, res_out;
  logic        res_full;
  logic [$clog2(RESQ_DEPTH):0] res_level;

  // Configuration register writes.
  assign cfg_ready = 1'b1;

  always_comb begin
    slots_nxt = slots_r;
    msgb_nxt  = msgb_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SLOTS: slots_nxt = cfg_data;
        CFG_MSGB:  msgb_nxt  = cfg_data[3:0];
        default:   slots_nxt = slots_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RST;
      msgb_r  <= MSGB_RST;
    end else begin
      slots_r <= slots_nxt;
      msgb_r  <= msgb_nxt;
    end
  end

  mcmr_front #(
    .CHANNELS   (CHANNELS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_op      (in_op),
    .in_channel (in_channel),
    .in_length  (in_length),
    .in_payload (in_payload),
    .msgb_cfg   (msgb_r),
    .clearing   (clearing),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd),
    .cmd_empty  (cmd_empty)
  );

  mcmr_back #(
    .CHANNELS   (CHANNELS),
    .MAX_SLOTS  (MAX_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .slots_cfg (slots_r),
    .msgb_cfg  (msgb_r),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_level (res_level),
    .res_push  (res_push),
    .res_data  (res_in),
    .clearing  (clearing)
  );

  // Result queue towards the consumer.
  mcmr_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty),
    .full  (res_full),
    .level (res_level)
  );

  // The back end reserves space by level, so the full flag is only informative.
  logic unused_full;
  assign unused_full = res_full;

  assign out_status     = res_out.status;
  assign out_count      = res_out.count;
  assign out_message    = res_out.message;
  assign out_idle_polls = res_out.idle_polls;

endmodule

### bench/mcmr_reply_checker.sv
// Reply checker for the message ring: predicts each reply from the requests taken and compares.
`timescale 1ns / 100ps

module mcmr_reply_checker
  import mcmr_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic        in_op,
  input  logic [3:0]  in_channel,
  input  logic [3:0]  in_length,
  input  logic [63:0] in_payload,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_count,
  input  logic [63:0] out_message,
  input  logic [31:0] out_idle_polls,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output int          mismatches,
  output int          replies_owed
);

  // Shadow copy of the configuration and of the ring state.
  logic [4:0]  ring_slots;
  logic [3:0]  msg_bytes;
  int          wr_ptr [CHANNELS];
  int          rd_ptr [CHANNELS];
  logic [63:0] slot_word [CHANNELS*MAX_SLOTS];
  logic [31:0] idle_run;

  // Replies predicted for requests taken but not yet popped, oldest first.
  res_t        owed_replies [$];
  res_t        want;

  // Ring length in force; larger settings act as the full ring.
  function automatic int used_slots();
    return (ring_slots > MAX_SLOTS) ? MAX_SLOTS : int'(ring_slots);
  endfunction

  // Message size in force; larger settings act as the slot width.
  function automatic int size_bytes();
    return (msg_bytes > SLOT_BYTES) ? SLOT_BYTES : int'(msg_bytes);
  endfunction

  // Pointer advance, wrapping at the ring length; a pointer left past a shrunk ring wraps too.
  function automatic int advance(int p);
    int n;
    n = p + 1;
    if (n >= used_slots()) n = 0;
    return n;
  endfunction

  // Mask covering the low n bytes of a slot word.
  function automatic logic [63:0] low_bytes(int n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // Applies one request to the shadow state and returns the reply it should give.
  function automatic res_t predict_reply(op_t op, logic [3:0] ch, logic [3:0] len,
                                         logic [63:0] pay);
    res_t        r;
    int          nxt;
    int          ix;
    logic [63:0] m;
    r.status  = ST_BAD;
    r.count   = '0;
    r.message = '0;
    if (ch < CHANNELS) begin
      if (op == OP_SEND) begin
        if (len != 0 && len <= size_bytes()) begin
          nxt = advance(wr_ptr[ch]);
          if (nxt == rd_ptr[ch]) begin
            r.status = ST_FULL;
          end else begin
            // Only the low length bytes of the slot are overwritten.
            m = low_bytes(len) & low_bytes(SLOT_BYTES);
            ix = ch * MAX_SLOTS + nxt;
            slot_word[ix] = (slot_word[ix] & ~m) | (pay & m);
            wr_ptr[ch] = nxt;
            r.status = ST_DONE;
            r.count  = len;
          end
        end
      end else if (rd_ptr[ch] == wr_ptr[ch]) begin
        idle_run = idle_run + 32'd1;
        r.status = ST_EMPTY;
      end else begin
        nxt = advance(rd_ptr[ch]);
        r.message = slot_word[ch * MAX_SLOTS + nxt] & low_bytes(SLOT_BYTES);
        rd_ptr[ch] = nxt;
        idle_run = '0;
        r.status = ST_DONE;
        r.count  = 4'(size_bytes());
      end
    end
    r.idle_polls = idle_run;
    return r;
  endfunction

  // Watch the three channels at each rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      ring_slots = SLOTS_RST;
      msg_bytes  = MSGB_RST;
      for (int c = 0; c < CHANNELS; c++) begin
        wr_ptr[c] = 0;
        rd_ptr[c] = 0;
      end
      for (int i = 0; i < CHANNELS * MAX_SLOTS; i++) slot_word[i] = '0;
      idle_run = '0;
      owed_replies.delete();
      mismatches   = 0;
      replies_owed = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SLOTS) ring_slots = cfg_data;
        else msg_bytes = cfg_data[3:0];
      end
      if (in_push && !in_full)
        owed_replies.push_back(predict_reply(op_t'(in_op), in_channel, in_length, in_payload));
      if (out_pop && !out_empty) begin
        if (owed_replies.size() == 0) begin
          $error("reply popped with no request waiting for it");
          mismatches++;
        end else begin
          want = owed_replies.pop_front();
          if (out_status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_count != want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_count);
            mismatches++;
          end
          if (out_message != want.message) begin
            $error("message: expected %h, got %h", want.message, out_message);
            mismatches++;
          end
          if (out_idle_polls != want.idle_polls) begin
            $error("idle_polls: expected %0d, got %0d", want.idle_polls, out_idle_polls);
            mismatches++;
          end
        end
      end
      replies_owed = owed_replies.size();
    end
  end

endmodule

### bench/multi_channel_message_ring_unit_tb.sv
// Testbench top for the message ring: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 100ps

module multi_channel_message_ring_unit_tb;
  import mcmr_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_REQUESTS = 125;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic        in_op;
  logic [3:0]  in_channel;
  logic [3:0]  in_length;
  logic [63:0] in_payload;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_status;
  logic [3:0]  out_count;
  logic [63:0] out_message;
  logic [31:0] out_idle_polls;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [4:0]  cfg_data;

  int          mismatches;
  int          replies_owed;
  bit          calm;        // set for the closing stretch: no idling on either side
  int          pop_hold;
  int          send_limit;  // send length in force, used to keep most sends well formed

  // Register settings per random phase; the last one restores the reset values.
  logic [4:0]  phase_slots [RANDOM_PHASES] = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd0, 5'd1, 5'd9, 5'd16};
  logic [4:0]  phase_msgb  [RANDOM_PHASES] = '{5'd8, 5'd1, 5'd15, 5'd3, 5'd8, 5'd4, 5'd0, 5'd24};

  multi_channel_message_ring_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_channel     (in_channel),
    .in_length      (in_length),
    .in_payload     (in_payload),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_message    (out_message),
    .out_idle_polls (out_idle_polls),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  mcmr_reply_checker reply_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_op          (in_op),
    .in_channel     (in_channel),
    .in_length      (in_length),
    .in_payload     (in_payload),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_count      (out_count),
    .out_message    (out_message),
    .out_idle_polls (out_idle_polls),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .replies_owed   (replies_owed)
  );

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Reply side: outside the closing stretch, pop is dropped at random and held low for a random hold time.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold = pop_hold - 1;
      out_pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      pop_hold = $urandom_range(0, 11);
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  // Watchdog: ends the run when nothing has been taken on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // Offers one request, after an optional gap, and waits until the block takes it.
  task automatic put_request(op_t op, logic [3:0] ch, logic [3:0] len, logic [63:0] pay);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push    <= 1'b1;
    in_op      <= op;
    in_channel <= ch;
    in_length  <= len;
    in_payload <= pay;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Stops offering requests and waits until every predicted reply has been popped.
  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
  endtask

  // Writes one configuration register through its own channel.
  task automatic write_reg(cfg_idx_t idx, logic [4:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MSGB) send_limit = (value[3:0] > 8) ? 8 : int'(value[3:0]);
  endtask

  // Random traffic in runs that lean towards sends or receives on one focus channel,
  // so that rings fill up and drain; a minority of requests are malformed.
  task automatic random_requests(int n);
    bit         sending;
    int         run;
    int         focus;
    op_t        op;
    logic [3:0] ch;
    logic [3:0] len;
    run = 0;
    sending = 1'b1;
    focus = 0;
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        sending = 1'($urandom_range(0, 1));
        run     = $urandom_range(1, 24);
        focus   = $urandom_range(0, DEF_CHANNELS - 1);
      end
      run--;
      if ($urandom_range(0, 99) < 80) op = sending ? OP_SEND : OP_RECV;
      else op = sending ? OP_RECV : OP_SEND;
      if ($urandom_range(0, 9) == 0) ch = 4'($urandom_range(DEF_CHANNELS, 15));
      else if ($urandom_range(0, 9) < 7) ch = 4'(focus);
      else ch = 4'($urandom_range(0, DEF_CHANNELS - 1));
      if ($urandom_range(0, 99) < 85 && send_limit > 0) len = 4'($urandom_range(1, send_limit));
      else len = 4'($urandom_range(0, 15));
      put_request(op, ch, len, {$urandom(), $urandom()});
    end
  endtask

  // Main sequence.
  initial begin
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_op      = OP_SEND;
    in_channel = '0;
    in_length  = '0;
    in_payload = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_SLOTS;
    cfg_data   = '0;
    calm       = 1'b0;
    pop_hold   = 0;
    send_limit = 8;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: empty polls, rejected channels and lengths, full and partial sends.
    put_request(OP_RECV, 4'd0, 4'd0, '0);
    put_request(OP_RECV, 4'd0, 4'd0, '0);
    put_request(OP_SEND, 4'd4, 4'd1, '1);
    put_request(OP_RECV, 4'd15, 4'd15, '1);
    put_request(OP_SEND, 4'd0, 4'd0, '1);
    put_request(OP_SEND, 4'd0, 4'd9, '1);
    put_request(OP_SEND, 4'd1, 4'd15, '1);
    put_request(OP_SEND, 4'd0, 4'd8, '1);
    put_request(OP_SEND, 4'd0, 4'd1, '0);
    put_request(OP_RECV, 4'd0, 4'd0, '0);
    put_request(OP_RECV, 4'd0, 4'd0, '0);
    put_request(OP_RECV, 4'd0, 4'd0, '0);
    put_request(OP_SEND, 4'd3, 4'd8, 64'h0123_4567_89ab_cdef);
    put_request(OP_RECV, 4'd3, 4'd0, '0);
    settle();

    // Two-slot ring and one-byte messages: full after one send, long send rejected.
    write_reg(CFG_SLOTS, 5'd2);
    write_reg(CFG_MSGB, 5'd1);
    put_request(OP_SEND, 4'd2, 4'd1, '1);
    put_request(OP_SEND, 4'd2, 4'd1, '1);
    put_request(OP_SEND, 4'd2, 4'd2, '1);
    put_request(OP_RECV, 4'd2, 4'd0, '0);
    put_request(OP_RECV, 4'd2, 4'd0, '0);
    settle();

    // Zero message size rejects every send; a zero-length ring wraps every pointer to slot 0.
    write_reg(CFG_SLOTS, 5'd0);
    write_reg(CFG_MSGB, 5'd0);
    put_request(OP_SEND, 4'd0, 4'd1, '1);
    put_request(OP_RECV, 4'd0, 4'd0, '0);
    settle();

    // Oversized message size with a one-slot ring: full at read pointer 0, shrunk-ring wrap.
    write_reg(CFG_MSGB, 5'd15);
    write_reg(CFG_SLOTS, 5'd1);
    put_request(OP_SEND, 4'd1, 4'd8, '1);
    put_request(OP_SEND, 4'd0, 4'd4, 64'hfedc_ba98_7654_3210);
    put_request(OP_RECV, 4'd0, 4'd0, '0);
    settle();

    // Random phases, each under its own register settings.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(CFG_SLOTS, phase_slots[p]);
      write_reg(CFG_MSGB, phase_msgb[p]);
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      random_requests(PHASE_REQUESTS);
      settle();
    end

    // Let any stray reply surface before the verdict.
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
sv/mcmr_pkg.sv
sv/mcmr_fifo.sv
sv/mcmr_front.sv
sv/mcmr_back.sv
sv/multi_channel_message_ring_unit.sv
bench/mcmr_reply_checker.sv
bench/multi_channel_message_ring_unit_tb.sv
